// ===== rtl/rnss_pkg.sv =====
// Shared types and constants of the ring nearest-slot search unit.
package rnss_pkg;

  // Width of the ring size register and its value after reset.
  localparam int unsigned RING_W     = 4;
  localparam logic [RING_W-1:0] RING_RESET = 4'd5;

  // Key width and result field widths.
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned STEPS_W  = 3;
  localparam int unsigned STATUS_W = 2;

  // Operation codes.
  localparam logic OP_PARK = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] card_key;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [SLOT_W-1:0]   slot_index;
    logic                clockwise;
    logic [STEPS_W-1:0]  steps;
    logic [STATUS_W-1:0] status;
  } out_t;

endpackage

// ===== rtl/rnss_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module rnss_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ring_nearest_slot_search_unit.sv =====
// Top level of the ring nearest-slot search unit: sequencer, slot flags and key RAM.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+-------------------------------
//   in      | input     | in_valid_i / in_ready_o   | in_data_i  (op, card_key)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (slot, dir, steps, status)
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (slots_in_use)
//
// An input transaction is taken in IDLE. NORM then subtracts the ring size from the current
// position until it lies inside the ring (no subtraction unless the ring was shrunk), and SCAN
// visits the slots one a cycle through the key RAM read port, clockwise then anticlockwise at
// each distance, until a slot matches or every slot of the ring has been visited. DONE then
// loads the result into the output register, and in_ready_o rises together with out_valid_o.
// Reset clears all occupied flags, the position and the output; the key RAM needs no
// clearing. A waiting result does not block the next transaction; only its DONE state
// waits for the output register to free up.
module ring_nearest_slot_search_unit
  import rnss_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [RING_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned SZ_W  = (IDX_W > RING_W) ? IDX_W : RING_W;

  typedef enum logic [1:0] {
    IDLE,
    NORM,
    SCAN,
    DONE
  } state_e;

  // Control registers.
  state_e              state_q, state_d;
  logic [RING_W-1:0]   ring_cfg_q, ring_cfg_d;
  logic [SLOT_COUNT-1:0] occ_q, occ_d;
  logic [IDX_W-1:0]    cur_pos_q, cur_pos_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_data_q, out_data_d;
  logic                more_q, more_d;
  logic                p_valid_q, p_valid_d;

  // Datapath registers.
  logic                op_q, op_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [IDX_W-1:0]    cw_idx_q, cw_idx_d;
  logic [IDX_W-1:0]    acw_idx_q, acw_idx_d;
  logic [RING_W-1:0]   dist_q, dist_d;
  logic                cand_acw_q, cand_acw_d;
  logic [IDX_W-1:0]    p_idx_q, p_idx_d;
  logic                p_cw_q, p_cw_d;
  logic [RING_W-1:0]   p_dist_q, p_dist_d;
  logic                found_q, found_d;
  logic [IDX_W-1:0]    res_idx_q, res_idx_d;
  logic                res_cw_q, res_cw_d;
  logic [RING_W-1:0]   res_dist_q, res_dist_d;

  // Key RAM ports.
  logic                ram_we;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [KEY_W-1:0]    ram_rdata;

  logic [RING_W-1:0]   ring_n;
  logic [SZ_W-1:0]     ring_ext;
  logic                hit;

  // Effective ring size: zero acts as one, larger than the slot count is clamped.
  always_comb begin
    if (ring_cfg_q == '0) begin
      ring_n = RING_W'(1);
    end else if (32'(ring_cfg_q) > SLOT_COUNT) begin
      ring_n = RING_W'(SLOT_COUNT);
    end else begin
      ring_n = ring_cfg_q;
    end
  end

  assign ring_ext = SZ_W'(ring_n);

  // The slot compared this cycle satisfies the search.
  assign hit = p_valid_q &&
               ((op_q == OP_PARK) ? !occ_q[p_idx_q]
                                  : (occ_q[p_idx_q] && (ram_rdata == key_q)));

  // Sequencer next-state logic.
  always_comb begin
    state_d     = state_q;
    ring_cfg_d  = ring_cfg_q;
    occ_d       = occ_q;
    cur_pos_d   = cur_pos_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    more_d      = more_q;
    p_valid_d   = p_valid_q;
    op_d        = op_q;
    key_d       = key_q;
    pos_d       = pos_q;
    cw_idx_d    = cw_idx_q;
    acw_idx_d   = acw_idx_q;
    dist_d      = dist_q;
    cand_acw_d  = cand_acw_q;
    p_idx_d     = p_idx_q;
    p_cw_d      = p_cw_q;
    p_dist_d    = p_dist_q;
    found_d     = found_q;
    res_idx_d   = res_idx_q;
    res_cw_d    = res_cw_q;
    res_dist_d  = res_dist_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = cand_acw_q ? acw_idx_q : cw_idx_q;

    // Configuration write.
    if (cfg_valid_i) begin
      ring_cfg_d = cfg_data_i;
    end

    // The output register empties when its transaction completes.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i.op;
          key_d   = in_data_i.card_key;
          pos_d   = cur_pos_q;
          state_d = NORM;
        end
      end

      // Bring the start position into the ring, one subtraction a cycle.
      NORM: begin
        if (SZ_W'(pos_q) >= ring_ext) begin
          pos_d = IDX_W'(SZ_W'(pos_q) - ring_ext);
        end else begin
          cw_idx_d   = pos_q;
          acw_idx_d  = pos_q;
          dist_d     = '0;
          cand_acw_d = 1'b0;
          more_d     = 1'b1;
          p_valid_d  = 1'b0;
          state_d    = SCAN;
        end
      end

      // Issue one slot read a cycle and compare the slot read the cycle before.
      SCAN: begin
        if (hit) begin
          found_d    = 1'b1;
          res_idx_d  = p_idx_q;
          res_cw_d   = p_cw_q;
          res_dist_d = p_dist_q;
          p_valid_d  = 1'b0;
          more_d     = 1'b0;
          state_d    = DONE;
        end else if (!more_q && !p_valid_q) begin
          found_d = 1'b0;
          state_d = DONE;
        end else begin
          p_valid_d = more_q;
          p_idx_d   = ram_raddr;
          p_cw_d    = !cand_acw_q;
          p_dist_d  = dist_q;
          ram_re    = more_q;
          if (more_q) begin
            if (!cand_acw_q) begin
              cand_acw_d = 1'b1;
            end else begin
              cand_acw_d = 1'b0;
              dist_d     = dist_q + RING_W'(1);
              if (SZ_W'(cw_idx_q) + SZ_W'(1) == ring_ext) begin
                cw_idx_d = '0;
              end else begin
                cw_idx_d = cw_idx_q + IDX_W'(1);
              end
              if (acw_idx_q == '0) begin
                acw_idx_d = IDX_W'(ring_ext - SZ_W'(1));
              end else begin
                acw_idx_d = acw_idx_q - IDX_W'(1);
              end
              if (SZ_W'(dist_q) + SZ_W'(1) == ring_ext) begin
                more_d = 1'b0;
              end
            end
          end
        end
      end

      // Commit the slot change and load the result once the output register is free.
      DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (found_q) begin
            out_data_d.slot_index = SLOT_W'(res_idx_q);
            out_data_d.clockwise  = res_cw_q;
            out_data_d.steps      = res_dist_q[STEPS_W-1:0];
            out_data_d.status     = ST_DONE;
            cur_pos_d             = res_idx_q;
            occ_d[res_idx_q]      = (op_q == OP_PARK);
            ram_we                = (op_q == OP_PARK);
          end else begin
            out_data_d.slot_index = SLOT_W'(pos_q);
            out_data_d.clockwise  = 1'b0;
            out_data_d.steps      = '0;
            out_data_d.status     = (op_q == OP_PARK) ? ST_FULL : ST_MISSING;
          end
          state_d = IDLE;
        end
      end

      default: begin
        state_d = IDLE;
      end
    endcase
  end

  // State, control flags and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      ring_cfg_q  <= RING_RESET;
      occ_q       <= '0;
      cur_pos_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      more_q      <= 1'b0;
      p_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ring_cfg_q  <= ring_cfg_d;
      occ_q       <= occ_d;
      cur_pos_q   <= cur_pos_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      more_q      <= more_d;
      p_valid_q   <= p_valid_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    pos_q      <= pos_d;
    cw_idx_q   <= cw_idx_d;
    acw_idx_q  <= acw_idx_d;
    dist_q     <= dist_d;
    cand_acw_q <= cand_acw_d;
    p_idx_q    <= p_idx_d;
    p_cw_q     <= p_cw_d;
    p_dist_q   <= p_dist_d;
    found_q    <= found_d;
    res_idx_q  <= res_idx_d;
    res_cw_q   <= res_cw_d;
    res_dist_q <= res_dist_d;
  end

  // Stored keys, one entry per slot.
  rnss_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOT_COUNT)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (res_idx_q),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
